FILE: rtl/adctm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adctm_pkg
// Shared constants for the converter trimmed-mean filter.
// ----------------------------------------------------------------------------
package adctm_pkg;

  // Default build parameters
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int MAX_KEPT_DEF    = 48;

  // Result field
  localparam int              OUT_BITS = 12;
  localparam logic [11:0]     OUT_MAX  = 12'hFFF;

  // Register widths
  localparam int DISC_W   = 4;
  localparam int KEPT_W   = 6;
  localparam int SHIFT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEPT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT   = 2'd2;

  // Register reset values
  localparam logic [DISC_W-1:0]  DISCARD_RST = 4'd2;
  localparam logic [KEPT_W-1:0]  KEPT_RST    = 6'd18;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 3'd4;

  // Smallest kept count honored
  localparam int KEPT_MIN = 2;

endpackage : adctm_pkg
`default_nettype wire

FILE: rtl/adctm_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adctm_accum
// Window position, running sum and max/min tracking for one window.
// ----------------------------------------------------------------------------
module adctm_accum #(
  parameter int SAMPLE_BITS = adctm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_KEPT    = adctm_pkg::MAX_KEPT_DEF,
  parameter int POS_W       = $clog2(MAX_KEPT + 16),
  parameter int SUM_W       = SAMPLE_BITS + POS_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [SAMPLE_BITS-1:0]         sample,
  input  wire logic [adctm_pkg::DISC_W-1:0]   discard_count,
  input  wire logic [adctm_pkg::KEPT_W-1:0]   kept_count,
  output logic                                close,
  output logic [SUM_W-1:0]                    sum_upd,
  output logic [SAMPLE_BITS-1:0]              largest_upd,
  output logic [SAMPLE_BITS-1:0]              smallest_upd
);
  import adctm_pkg::*;

  localparam int CW = (POS_W > KEPT_W) ? POS_W : KEPT_W;

  logic [POS_W-1:0]       pos_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] largest_r;
  logic [SAMPLE_BITS-1:0] smallest_r;

  logic [CW-1:0]    kept_x;
  logic [CW-1:0]    kept_eff;
  logic [POS_W-1:0] win_end;
  logic [POS_W-1:0] pos_inc;
  logic             in_keep;

  // clamp kept count to [KEPT_MIN, MAX_KEPT]
  always_comb begin
    kept_x = CW'(kept_count);
    if (kept_x < CW'(KEPT_MIN)) begin
      kept_eff = CW'(KEPT_MIN);
    end else if (kept_x > CW'(MAX_KEPT)) begin
      kept_eff = CW'(MAX_KEPT);
    end else begin
      kept_eff = kept_x;
    end
  end

  assign win_end = POS_W'(discard_count) + POS_W'(kept_eff);
  assign pos_inc = pos_r + POS_W'(1);
  assign in_keep = (pos_r >= POS_W'(discard_count));
  assign close   = (pos_inc >= win_end);

  assign largest_upd  = (in_keep && (sample > largest_r))  ? sample : largest_r;
  assign smallest_upd = (in_keep && (sample < smallest_r)) ? sample : smallest_r;
  assign sum_upd      = sum_r + (in_keep ? SUM_W'(sample) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_r      <= '0;
      largest_r  <= '0;
      smallest_r <= '1;
    end else if (step) begin
      if (close) begin
        pos_r      <= '0;
        sum_r      <= '0;
        largest_r  <= '0;
        smallest_r <= '1;
      end else begin
        pos_r      <= pos_inc;
        sum_r      <= sum_upd;
        largest_r  <= largest_upd;
        smallest_r <= smallest_upd;
      end
    end
  end

endmodule : adctm_accum
`default_nettype wire

FILE: rtl/adctm_trim.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adctm_trim
// Drops max and min from the window sum, shifts and saturates.
// ----------------------------------------------------------------------------
module adctm_trim #(
  parameter int SAMPLE_BITS = adctm_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = adctm_pkg::SAMPLE_BITS_DEF + 6
) (
  input  wire logic [SUM_W-1:0]               sum_in,
  input  wire logic [SAMPLE_BITS-1:0]         largest,
  input  wire logic [SAMPLE_BITS-1:0]         smallest,
  input  wire logic [adctm_pkg::SHIFT_W-1:0]  shift,
  output logic [adctm_pkg::OUT_BITS-1:0]      average
);
  import adctm_pkg::*;

  logic [SUM_W:0]   pair;
  logic [SUM_W-1:0] trimmed;
  logic [SUM_W-1:0] shifted;

  assign pair = (SUM_W+1)'(largest) + (SUM_W+1)'(smallest);

  // short windows after a mid-window register change can go negative
  assign trimmed = ({1'b0, sum_in} >= pair) ? SUM_W'({1'b0, sum_in} - pair) : '0;
  assign shifted = trimmed >> shift;
  assign average = (|shifted[SUM_W-1:OUT_BITS]) ? OUT_MAX : shifted[OUT_BITS-1:0];

endmodule : adctm_trim
`default_nettype wire

FILE: rtl/adc_trimmed_mean_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_trimmed_mean_filter_unit
// Trimmed-mean averaging filter for a converter sample stream.
// ----------------------------------------------------------------------------
// Each window is discard_count settling samples followed by kept_count
// (clamped to 2..MAX_KEPT) samples. Kept samples are summed while the largest
// and smallest are tracked; on the last sample of the window the max and min
// are removed, the rest is shifted right by average_shift and saturated to
// 4095, giving one result request; the window then restarts. Samples that do
// not close a window give no result. Throughput is one sample per clock
// while results are taken: a sample is captured in an input register, the
// window update (one add, two compares) and the trim/shift/saturate run
// combinationally on that register, and a result lands in the output
// register. While a result waits for out_ready the input register still
// takes one more sample; the input then stalls until the result is taken,
// whether or not the waiting sample closes a window. Register writes
// take effect at once and do not restart the window; write them only while
// the filter is idle. Writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_filter_unit #(
  parameter int SAMPLE_BITS = adctm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_KEPT    = adctm_pkg::MAX_KEPT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [adctm_pkg::OUT_BITS-1:0]         out_average,
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic [adctm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [adctm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import adctm_pkg::*;

  localparam int POS_W = $clog2(MAX_KEPT + 16);
  localparam int SUM_W = SAMPLE_BITS + POS_W;

  // configuration
  logic [DISC_W-1:0]  discard_count_r;
  logic [KEPT_W-1:0]  kept_count_r;
  logic [SHIFT_W-1:0] average_shift_r;

  // input register
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;

  // output register
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_average_r;

  logic                   adv;
  logic                   close;
  logic [SUM_W-1:0]       sum_upd;
  logic [SAMPLE_BITS-1:0] largest_upd;
  logic [SAMPLE_BITS-1:0] smallest_upd;
  logic [OUT_BITS-1:0]    average_nxt;

  // the captured sample moves on once the output slot is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_count_r <= DISCARD_RST;
      kept_count_r    <= KEPT_RST;
      average_shift_r <= SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISCARD: discard_count_r <= cfg_data[DISC_W-1:0];
        REG_KEPT:    kept_count_r    <= cfg_data[KEPT_W-1:0];
        REG_SHIFT:   average_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r <= in_sample;
    end
  end

  adctm_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_KEPT    (MAX_KEPT),
    .POS_W       (POS_W),
    .SUM_W       (SUM_W)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .sample        (s1_sample_r),
    .discard_count (discard_count_r),
    .kept_count    (kept_count_r),
    .close         (close),
    .sum_upd       (sum_upd),
    .largest_upd   (largest_upd),
    .smallest_upd  (smallest_upd)
  );

  adctm_trim #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_trim (
    .sum_in   (sum_upd),
    .largest  (largest_upd),
    .smallest (smallest_upd),
    .shift    (average_shift_r),
    .average  (average_nxt)
  );

  // result register: loads on window close, clears when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && close) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && close) begin
      out_average_r <= average_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule : adc_trimmed_mean_filter_unit
`default_nettype wire

FILE: verif/trimmed_mean_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_mean_checker
// Watches the sample, result and register ports of the trimmed-mean filter,
// predicts each window average and compares it with the result stream.
// ----------------------------------------------------------------------------
module trimmed_mean_checker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [11:0]                        in_sample,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [adctm_pkg::OUT_BITS-1:0]     out_average,
  input  wire logic                               cfg_we,
  input  wire logic [adctm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [adctm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                      mismatch_count,
  output int                                      averages_outstanding
);
  import adctm_pkg::*;

  localparam int KEPT_CEILING = MAX_KEPT_DEF;

  // filter settings as last written
  logic [DISC_W-1:0]    discard_setting;
  logic [KEPT_W-1:0]    kept_setting;
  logic [SHIFT_W-1:0]   shift_setting;

  // window state
  logic [7:0]           position;
  logic [17:0]          running_sum;
  logic [11:0]          largest;
  logic [11:0]          smallest;

  logic [OUT_BITS-1:0]  expected_averages[$];

  // Folds one sample into the window; on the closing sample it queues the
  // trimmed, shifted and saturated average and opens a fresh window.
  task automatic accumulate_sample(input logic [11:0] value);
    int          kept_eff;
    logic [12:0] extremes;
    logic [17:0] trimmed;
    logic [17:0] shifted;
    begin
      kept_eff = kept_setting;
      if (kept_eff < KEPT_MIN) kept_eff = KEPT_MIN;
      if (kept_eff > KEPT_CEILING) kept_eff = KEPT_CEILING;

      if (position >= discard_setting) begin
        if (value > largest) largest = value;
        if (value < smallest) smallest = value;
        running_sum = running_sum + value;
      end

      if (int'(position) + 1 < int'(discard_setting) + kept_eff) begin
        position = position + 1'b1;
      end else begin
        extremes = {1'b0, largest} + {1'b0, smallest};
        // a window shortened mid-flight can hold too little to trim
        trimmed  = (running_sum >= extremes) ? running_sum - extremes : '0;
        shifted  = trimmed >> shift_setting;
        expected_averages.push_back((shifted > OUT_MAX) ? OUT_MAX : shifted[11:0]);
        position    = '0;
        running_sum = '0;
        largest     = '0;
        smallest    = '1;
      end
    end
  endtask

  always @(posedge clk) begin
    logic [OUT_BITS-1:0] want;
    if (!rst_n) begin
      discard_setting = DISCARD_RST;
      kept_setting    = KEPT_RST;
      shift_setting   = SHIFT_RST;
      position        = '0;
      running_sum     = '0;
      largest         = '0;
      smallest        = '1;
      expected_averages.delete();
      mismatch_count       <= 0;
      averages_outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DISCARD: discard_setting = cfg_data[DISC_W-1:0];
          REG_KEPT:    kept_setting    = cfg_data[KEPT_W-1:0];
          REG_SHIFT:   shift_setting   = cfg_data[SHIFT_W-1:0];
          default: ;   // unused index, write dropped
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: average %0d arrived with none expected", $time, out_average);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_averages.pop_front();
          if (out_average !== want) begin
            $display("%0t: average mismatch: expected %0d, actual %0d",
                     $time, want, out_average);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end

      if (in_valid && in_ready) accumulate_sample(in_sample);

      averages_outstanding <= expected_averages.size();
    end
  end

endmodule : trimmed_mean_checker

FILE: verif/adc_trimmed_mean_filter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_trimmed_mean_filter_unit_test
// Stimulus and verdict for the converter trimmed-mean filter.
// ----------------------------------------------------------------------------
// A short directed run covers the window edge cases (window shrunk below the
// current position, a single kept sample, kept count clamping, saturation,
// shift of 7, unused register index). Random phases follow, each with fresh
// register settings written while the filter is drained, and sample streams
// that often end mid-window so the next settings land on a partial window.
// The sender runs in bursts with random gaps; the receiver stalls on its own
// pattern. All checking lives in trimmed_mean_checker.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_filter_unit_test;
  import adctm_pkg::*;

  localparam int RANDOM_SAMPLES = 1700;
  localparam int SETTLE_CYCLES  = 8;        // pipeline is two deep, pad it
  localparam int CYCLE_LIMIT    = 400000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_HELD_OFF
  } ready_mode_e;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [11:0]             in_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [OUT_BITS-1:0]     out_average;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int mismatch_count;
  int averages_outstanding;
  int cycle_count = 0;

  // sender burst bookkeeping and sample shaping for the current phase
  int burst_left = 0;
  int phase_center = 2048;
  int phase_spread = 4095;

  adc_trimmed_mean_filter_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  trimmed_mean_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_average          (out_average),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .mismatch_count       (mismatch_count),
    .averages_outstanding (averages_outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adc_trimmed_mean_filter_unit test failed");
      $finish;
    end
  end

  // Result side: runs of always-ready, coin-flip, sparse and fully held off.
  initial begin
    ready_mode_e mode;
    int          run;
    forever begin
      mode = ready_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(4, 60);
      repeat (run) begin
        @(posedge clk);
        case (mode)
          READY_ALWAYS:   out_ready <= 1'b1;
          READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          READY_HELD_OFF: out_ready <= 1'b0;
          default:        out_ready <= 1'b1;
        endcase
      end
    end
  end

  // One request on the sample channel. Valid is raised with the payload and
  // held until accepted; a gap may open before a new burst starts.
  task automatic send_sample(input logic [11:0] value);
    int gap;
    begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 20);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid  <= 1'b1;
      in_sample <= value;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
  endtask

  // Register write; the write enable drops before return so consecutive writes never share a step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every predicted average, then let in-flight samples
  // that close no window clear the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (averages_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rail values, full-range noise, or a cluster around the phase center.
  function automatic logic [11:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 4095;
      2, 3, 4: v = $urandom_range(0, 4095);
      default: begin
        v = phase_center + $urandom_range(0, 2 * phase_spread) - phase_spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
    endcase
    return v[11:0];
  endfunction

  initial begin : stimulus
    int                     sent;
    int                     phase;
    int                     count;
    int                     window_len;
    int                     kept_eff;
    logic [DISC_W-1:0]      discard_pick;
    logic [KEPT_W-1:0]      kept_pick;
    logic [SHIFT_W-1:0]     shift_pick;
    logic [CFG_DATA_W-1:0]  word;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---------------------------------------------------------
    // Two settling samples under reset settings, then shrink the window to
    // end before the current position: the next sample closes it alone and
    // the trim underflows to zero.
    send_sample(12'hAAA);
    send_sample(12'h555);
    settle();
    write_reg(REG_DISCARD, 6'd0);
    write_reg(REG_KEPT, 6'd2);
    send_sample(12'd3000);
    settle();

    // unused index is dropped; kept of 1 clamps to 2; shift of 7
    write_reg(REG_UNUSED, 6'h3F);
    write_reg(REG_KEPT, 6'd1);
    write_reg(REG_SHIFT, 6'd7);
    send_sample(12'hFFF);
    send_sample(12'h000);
    settle();

    // four full-scale samples, no shift: trimmed sum saturates
    write_reg(REG_KEPT, 6'd4);
    write_reg(REG_SHIFT, 6'd0);
    repeat (4) send_sample(12'hFFF);
    settle();

    // one settling sample, then alternating bit patterns
    write_reg(REG_DISCARD, 6'd1);
    write_reg(REG_KEPT, 6'd3);
    write_reg(REG_SHIFT, 6'd1);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'h800);
    settle();

    // shift of 7 with a nonzero average
    write_reg(REG_DISCARD, 6'd0);
    write_reg(REG_KEPT, 6'd5);
    write_reg(REG_SHIFT, 6'd7);
    repeat (5) send_sample(12'hFFF);
    settle();

    // --- random phases ----------------------------------------------------
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 5))
        0:       discard_pick = '0;
        1:       discard_pick = '1;
        default: discard_pick = DISC_W'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        0:       kept_pick = KEPT_W'($urandom_range(0, 1));
        1:       kept_pick = 6'd48;
        2:       kept_pick = KEPT_W'($urandom_range(49, 63));
        3:       kept_pick = 6'd2;
        default: kept_pick = KEPT_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       shift_pick = '0;
        1:       shift_pick = 3'd6;
        2:       shift_pick = 3'd7;
        default: shift_pick = SHIFT_W'($urandom_range(0, 7));
      endcase

      // open with the extreme corners
      if (phase == 0) begin
        discard_pick = 4'd15;
        kept_pick    = 6'd63;
        shift_pick   = 3'd6;
      end else if (phase == 1) begin
        discard_pick = 4'd0;
        kept_pick    = 6'd48;
        shift_pick   = 3'd0;
      end

      // spare high bits of the write data carry noise
      if (phase < 2 || $urandom_range(0, 3) != 0) begin
        word = CFG_DATA_W'($urandom_range(0, 63));
        word[DISC_W-1:0] = discard_pick;
        write_reg(REG_DISCARD, word);
      end
      if (phase < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(REG_KEPT, kept_pick);
      end
      if (phase < 2 || $urandom_range(0, 3) != 0) begin
        word = CFG_DATA_W'($urandom_range(0, 63));
        word[SHIFT_W-1:0] = shift_pick;
        write_reg(REG_SHIFT, word);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 63)));
      end

      // stream length from the picked settings; a skipped write only shifts
      // where the stream stops, the checker tracks the real settings
      kept_eff = kept_pick;
      if (kept_eff < KEPT_MIN) kept_eff = KEPT_MIN;
      if (kept_eff > MAX_KEPT_DEF) kept_eff = MAX_KEPT_DEF;
      window_len = int'(discard_pick) + kept_eff;
      count = $urandom_range(1, 4) * window_len;
      // often leave a partial window for the next settings to land on
      if ($urandom_range(0, 2) == 0) count += $urandom_range(1, window_len - 1);

      phase_center = $urandom_range(0, 4095);
      case ($urandom_range(0, 2))
        0:       phase_spread = 16;
        1:       phase_spread = 256;
        default: phase_spread = 4095;
      endcase

      repeat (count) begin
        send_sample(pick_sample());
        sent++;
      end
      settle();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("adc_trimmed_mean_filter_unit test passed");
    end else begin
      $display("adc_trimmed_mean_filter_unit test failed");
    end
    $finish;
  end

endmodule : adc_trimmed_mean_filter_unit_test
